FILE: src/msr_mass_matrix_assembler_core_assert.svh
// Assertion macros used by the assembler core module.
// Each macro expects the signals clk and arst_n in the module that uses it.
`ifndef MSR_MASS_MATRIX_ASSEMBLER_CORE_ASSERT_SVH
`define MSR_MASS_MATRIX_ASSEMBLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assembler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assembler assertion failed");

`endif

FILE: src/msr_pkg.sv
package msr_pkg;

	localparam int CFG_W  = 10;
	localparam int POS_W  = 23;
	localparam int COEF_W = 4;
	localparam int AREA_W = 32;
	localparam int QUO_W  = 28;
	localparam int REM_W  = 5;
	localparam int QDEPTH = 4;

	localparam logic [CFG_W-1:0]  SIDE_RESET = 10'd1;
	localparam logic [AREA_W-1:0] AREA_RESET = 32'd16777216;
	localparam logic [QUO_W-1:0]  QUO_RESET  = QUO_W'(AREA_RESET / 24);

	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_AREA = 2'd2;

	// Neighbor order within one matrix row.
	localparam int NB_RIGHT = 0;
	localparam int NB_DOWN  = 1;
	localparam int NB_DL    = 2;
	localparam int NB_LEFT  = 3;
	localparam int NB_UP    = 4;
	localparam int NB_UR    = 5;

	typedef enum logic [1:0] {
		KIND_ROW   = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_END   = 2'd2
	} msr_kind_t;

	typedef struct packed {
		logic [CFG_W-1:0] nx;
		logic [CFG_W-1:0] ny;
		logic [QUO_W-1:0] quo;
		logic [REM_W-1:0] rem;
		logic             busy;
	} msr_cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]  l;
		logic [POS_W-1:0]  r;
		logic [POS_W-1:0]  n;
		logic [POS_W-1:0]  end_ptr;
		logic [CFG_W:0]    nxp1;
		logic [5:0]        nmask;
		logic              row_edge;
		logic              col_edge;
		logic [COEF_W-1:0] diag_coef;
		logic              last_node;
	} msr_node_t;

	// floor(coef * rem / 24) for rem below 24, by a reciprocal multiply.
	function automatic logic [COEF_W-1:0] frac24(input logic [COEF_W-1:0] coef,
		input logic [REM_W-1:0] rem);
		logic [8:0]  x;
		logic [5:0]  y;
		logic [11:0] p;
		x = {5'b0, coef} * {4'b0, rem};
		y = x[8:3];
		p = {6'b0, y} * 12'd43;
		return p[10:7];
	endfunction

endpackage

FILE: src/msr_cfg.sv
module msr_cfg #(
	parameter int MAX_SIDE = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	output msr_pkg::msr_cfg_t cfg
);
	import msr_pkg::*;

	localparam int unsigned SIDE_LIM = MAX_SIDE - 1;
	localparam int RECIP_W = AREA_W - 3 + 32;
	localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;

	logic [CFG_W-1:0]   cols_q;
	logic [CFG_W-1:0]   rows_q;
	logic [AREA_W-1:0]  area_q;
	logic [QUO_W-1:0]   quo_q;
	logic               busy_q;
	logic [RECIP_W-1:0] recip_prod;
	logic               wr;

	assign cfg_ready = !busy_q;
	assign wr = cfg_valid && cfg_ready;
	assign recip_prod = RECIP_W'(area_q[AREA_W-1:3]) * RECIP_W'(RECIP_3);

	always_comb begin
		if (cols_q == '0) begin
			cfg.nx = CFG_W'(1);
		end else if (32'(cols_q) > SIDE_LIM) begin
			cfg.nx = CFG_W'(SIDE_LIM);
		end else begin
			cfg.nx = cols_q;
		end
		if (rows_q == '0) begin
			cfg.ny = CFG_W'(1);
		end else if (32'(rows_q) > SIDE_LIM) begin
			cfg.ny = CFG_W'(SIDE_LIM);
		end else begin
			cfg.ny = rows_q;
		end
		cfg.quo  = quo_q;
		cfg.rem  = area_q[REM_W-1:0] - {quo_q[0], 4'b0} - {quo_q[1:0], 3'b0};
		cfg.busy = busy_q;
	end

	// The area is kept as 24*quo + rem. The quotient is (area/8)/3 by a reciprocal
	// multiply in the cycle after the write; the remainder follows from the low bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= SIDE_RESET;
			rows_q <= SIDE_RESET;
			area_q <= AREA_RESET;
			quo_q  <= QUO_RESET;
			busy_q <= 1'b0;
		end else if (busy_q) begin
			quo_q  <= recip_prod[RECIP_W-1 -: QUO_W];
			busy_q <= 1'b0;
		end else if (wr) begin
			unique case (cfg_index)
				REG_COLS: cols_q <= cfg_data[CFG_W-1:0];
				REG_ROWS: rows_q <= cfg_data[CFG_W-1:0];
				REG_AREA: begin
					area_q <= cfg_data;
					busy_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: src/msr_front.sv
module msr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  msr_pkg::msr_cfg_t  cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	input  logic               q_full,
	output logic               push,
	output msr_pkg::msr_node_t node
);
	import msr_pkg::*;

	logic [CFG_W-1:0]   col_q;
	logic [CFG_W-1:0]   row_q;
	logic [POS_W-1:0]   off_q;
	logic               finished_q;
	logic [CFG_W-1:0]   cur_col;
	logic [CFG_W-1:0]   cur_row;
	logic [POS_W-1:0]   cur_off;
	logic               cur_fin;
	logic               beyond;
	logic               accept;
	logic [CFG_W:0]     nxp1;
	logic [CFG_W:0]     nyp1;
	logic [2*CFG_W+1:0] n_full;
	logic [2*CFG_W+1:0] l_full;
	logic [5:0]         nmask;
	logic [2:0]         tri_cnt;
	logic [2:0]         m;
	logic [POS_W-1:0]   next_off;
	logic               row_done;
	logic               grid_done;

	assign in_ready = !q_full && !cfg.busy;
	assign accept = in_valid && in_ready;
	assign nxp1 = {1'b0, cfg.nx} + 1'b1;
	assign nyp1 = {1'b0, cfg.ny} + 1'b1;
	assign n_full = (2*CFG_W+2)'(nxp1) * (2*CFG_W+2)'(nyp1);

	always_comb begin
		cur_col = restart ? '0 : col_q;
		cur_row = restart ? '0 : row_q;
		cur_off = restart ? POS_W'(n_full + 1'b1) : off_q;
		cur_fin = restart ? 1'b0 : finished_q;
		beyond = (cur_col > cfg.nx) || (cur_row > cfg.ny);
		l_full = (2*CFG_W+2)'(cur_row) * (2*CFG_W+2)'(nxp1) + (2*CFG_W+2)'(cur_col);

		nmask[NB_RIGHT] = cur_col < cfg.nx;
		nmask[NB_DOWN]  = cur_row > '0;
		nmask[NB_DL]    = (cur_col > '0) && (cur_row > '0);
		nmask[NB_LEFT]  = cur_col > '0;
		nmask[NB_UP]    = cur_row < cfg.ny;
		nmask[NB_UR]    = (cur_col < cfg.nx) && (cur_row < cfg.ny);

		tri_cnt = 3'(2 * nmask[NB_UR]) + 3'(2 * nmask[NB_DL])
			+ 3'(nmask[NB_LEFT] && nmask[NB_UP]) + 3'(nmask[NB_RIGHT] && nmask[NB_DOWN]);
		m = 3'($countones(nmask));
		next_off = cur_off + POS_W'(m);
		row_done = cur_col == cfg.nx;
		grid_done = row_done && (cur_row == cfg.ny);

		node.l         = POS_W'(l_full);
		node.r         = cur_off;
		node.n         = POS_W'(n_full);
		node.end_ptr   = next_off;
		node.nxp1      = nxp1;
		node.nmask     = nmask;
		node.row_edge  = (cur_row == '0) || (cur_row == cfg.ny);
		node.col_edge  = (cur_col == '0) || (cur_col == cfg.nx);
		node.diag_coef = {tri_cnt, 1'b0};
		node.last_node = grid_done;
	end

	assign push = accept && !cur_fin && !beyond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			off_q      <= '0;
			finished_q <= 1'b1;
		end else if (accept && !cur_fin) begin
			if (beyond) begin
				col_q      <= cur_col;
				row_q      <= cur_row;
				off_q      <= cur_off;
				finished_q <= 1'b1;
			end else begin
				off_q      <= next_off;
				finished_q <= grid_done;
				if (row_done) begin
					col_q <= '0;
					row_q <= grid_done ? '0 : cur_row + 1'b1;
				end else begin
					col_q <= cur_col + 1'b1;
					row_q <= cur_row;
				end
			end
		end
	end

endmodule

FILE: src/msr_queue.sv
module msr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  msr_pkg::msr_node_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output msr_pkg::msr_node_t head
);
	import msr_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	msr_node_t        mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = cnt_q == CNT_W'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: src/msr_back.sv
module msr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  msr_pkg::msr_cfg_t  cfg,
	input  logic               node_valid,
	input  msr_pkg::msr_node_t node,
	output logic               node_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_kind,
	output logic [22:0]        out_position,
	output logic [22:0]        out_index,
	output logic [3:0]         out_coef,
	output logic [31:0]        out_value,
	output logic               out_last
);
	import msr_pkg::*;

	localparam logic [2:0] SLOT_ROW   = 3'd0;
	localparam logic [2:0] SLOT_RIGHT = 3'(NB_RIGHT + 1);
	localparam logic [2:0] SLOT_DOWN  = 3'(NB_DOWN + 1);
	localparam logic [2:0] SLOT_DL    = 3'(NB_DL + 1);
	localparam logic [2:0] SLOT_LEFT  = 3'(NB_LEFT + 1);
	localparam logic [2:0] SLOT_UP    = 3'(NB_UP + 1);
	localparam logic [2:0] SLOT_UR    = 3'(NB_UR + 1);
	localparam logic [2:0] SLOT_END   = 3'd7;

	logic              have_q;
	msr_node_t         cur_q;
	logic [7:0]        pend_q;
	logic [2:0]        cnt_q;
	logic [2:0]        sel;
	logic [7:0]        pend_clr;
	logic              emit_last;
	logic              emit;
	logic              advance;
	msr_kind_t         e_kind;
	logic [POS_W-1:0]  e_pos;
	logic [POS_W-1:0]  e_idx;
	logic [COEF_W-1:0] e_coef;
	logic [POS_W-1:0]  slot_pos;
	logic [POS_W-1:0]  stride;
	logic [COEF_W-1:0] row_coef;
	logic [COEF_W-1:0] col_coef;

	logic              v_s1;
	msr_kind_t         kind_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [POS_W-1:0]  idx_s1;
	logic [COEF_W-1:0] coef_s1;
	logic              last_s1;
	logic [AREA_W-1:0] prod_s1;
	logic [COEF_W-1:0] frac_s1;

	logic              out_v_q;
	msr_kind_t         kind_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  idx_q;
	logic [COEF_W-1:0] coef_q;
	logic [AREA_W-1:0] value_q;
	logic              last_q;

	assign advance = !out_v_q || out_ready;
	assign emit = have_q && advance;

	always_comb begin
		sel = SLOT_ROW;
		for (int b = 7; b >= 0; b--) begin
			if (pend_q[b]) begin
				sel = 3'(b);
			end
		end
	end

	assign pend_clr = pend_q & ~(8'b1 << sel);
	assign emit_last = pend_clr == '0;
	assign node_pop = node_valid && (!have_q || (emit && emit_last));

	assign slot_pos = cur_q.r + POS_W'(cnt_q);
	assign stride = POS_W'(cur_q.nxp1);
	assign row_coef = cur_q.row_edge ? COEF_W'(1) : COEF_W'(2);
	assign col_coef = cur_q.col_edge ? COEF_W'(1) : COEF_W'(2);

	always_comb begin
		e_kind = KIND_ENTRY;
		e_pos  = slot_pos;
		e_idx  = cur_q.l;
		e_coef = COEF_W'(2);
		unique case (sel)
			SLOT_ROW: begin
				e_kind = KIND_ROW;
				e_pos  = cur_q.l;
				e_idx  = cur_q.r;
				e_coef = cur_q.diag_coef;
			end
			SLOT_RIGHT: begin
				e_idx  = cur_q.l + POS_W'(1);
				e_coef = row_coef;
			end
			SLOT_DOWN: begin
				e_idx  = cur_q.l - stride;
				e_coef = col_coef;
			end
			SLOT_DL: begin
				e_idx  = cur_q.l - stride - POS_W'(1);
			end
			SLOT_LEFT: begin
				e_idx  = cur_q.l - POS_W'(1);
				e_coef = row_coef;
			end
			SLOT_UP: begin
				e_idx  = cur_q.l + stride;
				e_coef = col_coef;
			end
			SLOT_UR: begin
				e_idx  = cur_q.l + stride + POS_W'(1);
			end
			SLOT_END: begin
				e_kind = KIND_END;
				e_pos  = cur_q.n;
				e_idx  = cur_q.end_ptr;
				e_coef = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			pend_q  <= '0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (node_pop) begin
				have_q <= 1'b1;
				pend_q <= {node.last_node, node.nmask, 1'b1};
				cnt_q  <= '0;
			end else if (emit) begin
				pend_q <= pend_clr;
				if (emit_last) begin
					have_q <= 1'b0;
				end
				if (sel != SLOT_ROW && sel != SLOT_END) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (advance) begin
				v_s1    <= emit;
				out_v_q <= v_s1;
			end
		end
	end

	// The mass term is coef*quo + floor(coef*rem/24) with area = 24*quo + rem.
	always_ff @(posedge clk) begin
		if (node_pop) begin
			cur_q <= node;
		end
		if (advance) begin
			kind_s1 <= e_kind;
			pos_s1  <= e_pos;
			idx_s1  <= e_idx;
			coef_s1 <= e_coef;
			last_s1 <= emit_last;
			prod_s1 <= AREA_W'(e_coef) * AREA_W'(cfg.quo);
			frac_s1 <= frac24(e_coef, cfg.rem);
			kind_q  <= kind_s1;
			pos_q   <= pos_s1;
			idx_q   <= idx_s1;
			coef_q  <= coef_s1;
			value_q <= prod_s1 + AREA_W'(frac_s1);
			last_q  <= last_s1;
		end
	end

	assign out_valid    = out_v_q;
	assign out_kind     = kind_q;
	assign out_position = pos_q;
	assign out_index    = idx_q;
	assign out_coef     = coef_q;
	assign out_value    = value_q;
	assign out_last     = last_q;

endmodule

FILE: src/msr_mass_matrix_assembler_core.sv
// Channel   Direction  Contents
// s_axis    in         tdata[0] restart
// m_axis    out        tuser kind; tdata position, index_value, coef_numerator, value; tlast
// cfg       in         cfg_index register number, cfg_data register value
//
// The front takes one input transaction per cycle while its four-entry node queue has room.
// The result port gives one result per cycle while it is not stalled; a node gives its row
// start, two to six neighbors and, after the last node, the end pointer.
// A node is taken from the queue head into cur_q; results pass the s1 and output registers.
// Reset clears the node counters and the offset and marks the matrix finished.
// A write of cell_area starts a split of the area by 24; cfg_ready and
// s_axis_tready are low while it runs. A stalled result port holds only the back end; the
// front keeps filling the queue.
`include "msr_mass_matrix_assembler_core_assert.svh"

module msr_mass_matrix_assembler_core #(
	parameter int MAX_SIDE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,   // position, index_value, coef_numerator, value, zero
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import msr_pkg::*;

	msr_cfg_t          cfg;
	msr_node_t         push_node;
	msr_node_t         head_node;
	logic              push;
	logic              q_full;
	logic              q_not_empty;
	logic              pop;
	logic [POS_W-1:0]  position;
	logic [POS_W-1:0]  index_value;
	logic [COEF_W-1:0] coef_numerator;
	logic [AREA_W-1:0] value;

	msr_cfg #(
		.MAX_SIDE(MAX_SIDE)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	msr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.restart (s_axis_tdata[0]),
		.q_full  (q_full),
		.push    (push),
		.node    (push_node)
	);

	msr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_node),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.head     (head_node)
	);

	msr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.node_valid  (q_not_empty),
		.node        (head_node),
		.node_pop    (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_kind    (m_axis_tuser),
		.out_position(position),
		.out_index   (index_value),
		.out_coef    (coef_numerator),
		.out_value   (value),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, value, coef_numerator, index_value, position};

	`MSR_ASSERT_NOW(a_end_is_last, m_axis_tvalid && m_axis_tuser == KIND_END, m_axis_tlast)
	`MSR_ASSERT_NOW(a_entry_coef, m_axis_tvalid && m_axis_tuser == KIND_ENTRY,
		coef_numerator == 4'd1 || coef_numerator == 4'd2)
	`MSR_ASSERT_NEXT(a_area_starts_div, cfg_valid && cfg_ready && cfg_index == REG_AREA,
		cfg.busy && !s_axis_tready)
	`MSR_ASSERT_NOW(a_no_push_when_full, push, !q_full)

endmodule

FILE: tb/tb_msr_mass_matrix_assembler_core.sv
`timescale 1ns / 100ps

import msr_pkg::*;

typedef struct {
	msr_kind_t   kind;
	logic [22:0] position;
	logic [22:0] index_value;
	logic [3:0]  coef;
	logic [31:0] value;
	logic        last;
} mass_entry_t;

class mass_matrix_scoreboard;
	localparam int unsigned SIDE_MAX = 1023;

	logic [9:0]  cols_reg;
	logic [9:0]  rows_reg;
	logic [31:0] area_reg;
	int unsigned col_ctr;
	int unsigned row_ctr;
	logic [22:0] offset;
	bit          done;
	mass_entry_t entry_q[$];
	int          errors;

	function new();
		cols_reg = 10'd1;
		rows_reg = 10'd1;
		area_reg = 32'd16777216;
		col_ctr = 0;
		row_ctr = 0;
		offset = '0;
		done = 1;
		errors = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			REG_COLS: cols_reg = data[9:0];
			REG_ROWS: rows_reg = data[9:0];
			REG_AREA: area_reg = data;
			default: ;
		endcase
	endfunction

	function int unsigned grid_side(logic [9:0] v);
		if (v == 0) return 1;
		if (v > SIDE_MAX) return SIDE_MAX;
		return v;
	endfunction

	function void push_entry(msr_kind_t kind, int unsigned pos, int unsigned idx,
		int unsigned coef);
		mass_entry_t e;
		longint unsigned prod;
		prod = area_reg;
		prod = prod * coef;
		e.kind = kind;
		e.position = pos[22:0];
		e.index_value = idx[22:0];
		e.coef = coef[3:0];
		e.value = 32'(prod / 24);
		e.last = 1'b0;
		entry_q.push_back(e);
	endfunction

	// Works out the matrix row of the node that one accepted input advances.
	function void note_node_input(bit restart);
		int unsigned nx, ny, n, i, j, l, r, m, tri_cnt, w;
		nx = grid_side(cols_reg);
		ny = grid_side(rows_reg);
		n = (nx + 1) * (ny + 1);
		w = nx + 1;
		if (restart) begin
			col_ctr = 0;
			row_ctr = 0;
			offset = 23'(n + 1);
			done = 0;
		end
		if (done) return;
		if (col_ctr > nx || row_ctr > ny) begin
			done = 1;
			return;
		end
		i = col_ctr;
		j = row_ctr;
		l = i + j * w;
		r = offset;
		tri_cnt = 0;
		if (i < nx && j < ny) tri_cnt += 2;
		if (i > 0 && j > 0) tri_cnt += 2;
		if (i > 0 && j < ny) tri_cnt += 1;
		if (i < nx && j > 0) tri_cnt += 1;
		push_entry(KIND_ROW, l, r, 2 * tri_cnt);
		m = 0;
		if (i < nx) begin
			push_entry(KIND_ENTRY, r + m, l + 1, (j == 0 || j == ny) ? 1 : 2);
			m++;
		end
		if (j > 0) begin
			push_entry(KIND_ENTRY, r + m, l - w, (i == 0 || i == nx) ? 1 : 2);
			m++;
		end
		if (i > 0 && j > 0) begin
			push_entry(KIND_ENTRY, r + m, l - w - 1, 2);
			m++;
		end
		if (i > 0) begin
			push_entry(KIND_ENTRY, r + m, l - 1, (j == 0 || j == ny) ? 1 : 2);
			m++;
		end
		if (j < ny) begin
			push_entry(KIND_ENTRY, r + m, l + w, (i == 0 || i == nx) ? 1 : 2);
			m++;
		end
		if (i < nx && j < ny) begin
			push_entry(KIND_ENTRY, r + m, l + w + 1, 2);
			m++;
		end
		offset = 23'(r + m);
		col_ctr = i + 1;
		if (col_ctr > nx) begin
			col_ctr = 0;
			row_ctr = j + 1;
			if (row_ctr > ny) begin
				row_ctr = 0;
				done = 1;
				push_entry(KIND_END, n, offset, 0);
			end
		end
		entry_q[entry_q.size() - 1].last = 1'b1;
	endfunction

	function void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
		if (actv !== expv) begin
			$display("%0t mismatch in %s: expected %0h, actual %0h", $time, name, expv, actv);
			errors++;
		end
	endfunction

	function void check_result(logic [1:0] kind, logic [22:0] pos, logic [22:0] idx,
		logic [3:0] coef, logic [31:0] value, logic last);
		mass_entry_t e;
		if (entry_q.size() == 0) begin
			$display("%0t unexpected result: expected none, actual kind %0h position %0h",
				$time, kind, pos);
			errors++;
			return;
		end
		e = entry_q.pop_front();
		compare_field("kind", 32'(e.kind), 32'(kind));
		compare_field("position", 32'(e.position), 32'(pos));
		compare_field("index_value", 32'(e.index_value), 32'(idx));
		compare_field("coef_numerator", 32'(e.coef), 32'(coef));
		compare_field("value", e.value, value);
		compare_field("last", 32'(e.last), 32'(last));
	endfunction
endclass

module tb_msr_mass_matrix_assembler_core;
	localparam int SETTLE_CYCLES  = 60;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 110;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	mass_matrix_scoreboard sb = new();
	int idle_cycles = 0;
	int burst_left = 0;
	int hold_requests = 0;

	msr_mass_matrix_assembler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tuser, m_axis_tdata[22:0], m_axis_tdata[45:23],
					m_axis_tdata[49:46], m_axis_tdata[81:50], m_axis_tlast);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_node_input(s_axis_tdata[0]);
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	// The result side stalls in stretches of changing density, and holds off for a long
	// time whenever the stimulus asks for it.
	initial begin
		int mode_left;
		int stall_pct;
		int hold_served;
		mode_left = 0;
		stall_pct = 0;
		hold_served = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				hold_served++;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(10, 60);
					case ($urandom_range(0, 2))
						0: stall_pct = 0;
						1: stall_pct = 30;
						default: stall_pct = 75;
					endcase
				end
				mode_left--;
				m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	task automatic offer_input(bit restart, bit steady);
		int gap;
		if (!steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					s_axis_tvalid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {7'b0, restart};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic walk_nodes(bit restart, int count);
		offer_input(restart, 1'b0);
		repeat (count - 1) offer_input(1'b0, 1'b0);
	endtask

	task automatic program_reg(logic [1:0] idx, logic [31:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic settle();
		while (sb.entry_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_side();
		logic [9:0] side;
		case ($urandom_range(0, 9))
			0: side = 10'd0;
			1: side = 10'd1023;
			default: side = 10'($urandom_range(1, 5));
		endcase
		return {22'($urandom), side};
	endfunction

	initial begin
		int sent;
		int count;
		bit first_phase;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_COLS;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Finished after reset, a full 2x2-node matrix, then an input past its end.
		offer_input(1'b0, 1'b0);
		walk_nodes(1'b1, 4);
		offer_input(1'b0, 1'b0);
		settle();

		// A zero width is taken as one; the largest area.
		program_reg(REG_COLS, 32'd0);
		program_reg(REG_ROWS, 32'd2);
		program_reg(REG_AREA, 32'hFFFF_FFFF);
		walk_nodes(1'b1, 6);
		settle();

		// Interior node and a restart in the middle of a matrix, with zero area.
		program_reg(REG_COLS, 32'd2);
		program_reg(REG_AREA, 32'd0);
		walk_nodes(1'b1, 4);
		walk_nodes(1'b1, 9);
		settle();

		// Largest grid, then shrunk under the running counters.
		program_reg(REG_COLS, 32'hFFFF_FFFF);
		program_reg(REG_ROWS, 32'd1023);
		program_reg(REG_AREA, $urandom);
		walk_nodes(1'b1, 3);
		settle();
		program_reg(REG_COLS, 32'd1);
		program_reg(REG_ROWS, 32'd1);
		walk_nodes(1'b0, 2);
		settle();

		sent = 0;
		first_phase = 1;
		while (sent < RANDOM_ITEMS) begin
			if (first_phase || $urandom_range(0, 1) == 0) begin
				program_reg(REG_COLS, first_phase ? 32'd3 : pick_side());
				program_reg(REG_ROWS, first_phase ? 32'd3 : pick_side());
				program_reg(REG_AREA, $urandom);
			end
			count = first_phase ? 30 : $urandom_range(8, 30);
			if (first_phase) begin
				hold_requests++;
			end
			for (int k = 0; k < count; k++) begin
				if (k == 0) begin
					offer_input($urandom_range(0, 3) != 0, first_phase);
				end else begin
					offer_input($urandom_range(0, 19) == 0, first_phase);
				end
			end
			sent += count;
			first_phase = 0;
			settle();
		end

		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
